// ===== rtl/core/fifo_tiebreak_priority_queue_macros.svh =====
// Assertion helpers used by the queue controller (ftpq_ctrl).
`ifndef FIFO_TIEBREAK_PRIORITY_QUEUE_MACROS_SVH
`define FIFO_TIEBREAK_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FTPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FTPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ftpq_pkg.sv =====
package ftpq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_PEEK    = 2'd2,
        OP_MODIFY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    localparam int TAG_W   = 32;
    localparam int PRIO_W  = 32;
    localparam int ORDER_W = 64;
    localparam int COUNT_W = 7;

    typedef struct packed {
        op_t                        opcode;
        logic [TAG_W-1:0]           value_tag;
        logic signed [PRIO_W-1:0]   priority_req;
    } in_item_t;

    typedef struct packed {
        status_t                    status;
        logic [TAG_W-1:0]           result_tag;
        logic signed [PRIO_W-1:0]   result_priority;
        logic [COUNT_W-1:0]         entry_count;
    } out_item_t;

    // One table row as stored in memory.
    typedef struct packed {
        logic                       valid;
        logic [TAG_W-1:0]           tag;
        logic signed [PRIO_W-1:0]   prio;
        logic [ORDER_W-1:0]         order;
    } entry_t;

    // Higher priority wins; on a tie the smaller order number (older) wins.
    function automatic logic ranks_above(entry_t a, entry_t b);
        if (a.prio != b.prio) begin
            return $signed(a.prio) > $signed(b.prio);
        end
        return a.order < b.order;
    endfunction

endpackage

// ===== rtl/core/fifo_tiebreak_priority_queue.sv =====
// Max-priority queue of up to CAPACITY entries (32-bit tag, signed 32-bit
// priority), ties going to the oldest insert. Every operation returns one
// result beat with status and the entry count after it. All entry data lives
// in one single-port-read table; each operation walks the whole table through
// that read port, so an operation runs these steps from accept until the next
// accept: one read per row, one step to take in the last read, one to commit
// the write back, one to hand the result to the output register and an idle
// step with s_ready high. The result sits in an output register, so the next
// operation can start while it waits on m_ready; a second result stalls the
// block until the first is taken. After reset the table is swept invalid, one
// entry per cycle, and s_ready stays low until that sweep is done.
module fifo_tiebreak_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ftpq_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ftpq_pkg::out_item_t m_item
);
    import ftpq_pkg::*;

    logic      res_valid;
    logic      res_ready;
    out_item_t res_item;
    logic      m_valid_reg;
    out_item_t m_item_reg;

    ftpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd_item  (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    // Hold the result beat until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
            if (res_valid) begin
                m_item_reg <= res_item;
            end
        end
    end

endmodule

// ===== rtl/core/ftpq_mem.sv =====
module ftpq_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  ftpq_pkg::entry_t  wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output ftpq_pkg::entry_t  rdata
);
    import ftpq_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/ftpq_ctrl.sv =====
module ftpq_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ftpq_pkg::in_item_t  cmd_item,
    output logic                res_valid,
    input  logic                res_ready,
    output ftpq_pkg::out_item_t res_item
);
    import ftpq_pkg::*;
    `include "fifo_tiebreak_priority_queue_macros.svh"

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        SCAN,
        DRAIN,
        COMMIT,
        HANDOFF
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       addr_reg;
    logic                rd_pend_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic                found_reg;
    entry_t              best_reg;
    logic [AW-1:0]       best_idx_reg;
    op_t                 op_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [PRIO_W-1:0]   pri_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [ORDER_W-1:0]  seq_reg;
    logic                res_valid_reg;
    out_item_t           res_item_reg;

    entry_t              rd_data;
    logic                take;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    entry_t              mem_wdata;
    logic                mem_re;
    status_t             status_next;
    logic [CNT_W-1:0]    count_next;
    logic [ORDER_W-1:0]  seq_next;
    logic [TAG_W-1:0]    rtag_next;
    logic [PRIO_W-1:0]   rpri_next;

    ftpq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    assign cmd_ready = (state_reg == IDLE);
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;
    assign mem_re    = (state_reg == SCAN);

    // Judge the row read back in the previous cycle against the running pick.
    always_comb begin
        take = 1'b0;
        if (rd_pend_reg) begin
            unique case (op_reg)
                OP_INSERT: take = !rd_data.valid && !found_reg;
                OP_EXTRACT, OP_PEEK:
                    take = rd_data.valid && (!found_reg || ranks_above(rd_data, best_reg));
                OP_MODIFY:
                    take = rd_data.valid && (rd_data.tag == tag_reg) &&
                           (!found_reg || (rd_data.order < best_reg.order));
                default: take = 1'b0;
            endcase
        end
    end

    // Outcome of the finished scan, and the single write back, if any, that it needs.
    always_comb begin
        status_next = ST_OK;
        count_next  = count_reg;
        seq_next    = seq_reg;
        rtag_next   = '0;
        rpri_next   = '0;
        mem_we      = 1'b0;
        mem_waddr   = best_idx_reg;
        mem_wdata   = best_reg;
        unique case (op_reg)
            OP_INSERT: begin
                if (found_reg) begin
                    mem_we          = 1'b1;
                    mem_wdata.valid = 1'b1;
                    mem_wdata.tag   = tag_reg;
                    mem_wdata.prio  = pri_reg;
                    mem_wdata.order = seq_reg;
                    count_next      = count_reg + 1'b1;
                    seq_next        = seq_reg + 1'b1;
                end else begin
                    status_next = ST_FULL;
                end
            end
            OP_EXTRACT, OP_PEEK: begin
                if (found_reg) begin
                    rtag_next = best_reg.tag;
                    rpri_next = best_reg.prio;
                    if (op_reg == OP_EXTRACT) begin
                        mem_we          = 1'b1;
                        mem_wdata.valid = 1'b0;
                        count_next      = count_reg - 1'b1;
                    end
                end else begin
                    status_next = ST_EMPTY;
                end
            end
            OP_MODIFY: begin
                if (found_reg) begin
                    mem_we         = 1'b1;
                    mem_wdata.prio = pri_reg;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default: status_next = ST_OK;
        endcase
        if (state_reg != COMMIT) begin
            mem_we = 1'b0;
        end
        // Sweep the table invalid after reset.
        if (state_reg == CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = addr_reg;
            mem_wdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CLEAR;
            addr_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            seq_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            // A read issued this cycle lands next cycle.
            rd_pend_reg <= (state_reg == SCAN);
            unique case (state_reg)
                CLEAR: begin
                    if (addr_reg == LAST_ADDR) begin
                        addr_reg  <= '0;
                        state_reg <= IDLE;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                IDLE: begin
                    if (cmd_valid) begin
                        op_reg    <= cmd_item.opcode;
                        tag_reg   <= cmd_item.value_tag;
                        pri_reg   <= cmd_item.priority_req;
                        found_reg <= 1'b0;
                        addr_reg  <= '0;
                        state_reg <= SCAN;
                    end
                end
                SCAN: begin
                    rd_idx_reg  <= addr_reg;
                    if (addr_reg == LAST_ADDR) begin
                        state_reg <= DRAIN;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                DRAIN: begin
                    state_reg <= COMMIT;
                end
                COMMIT: begin
                    count_reg                    <= count_next;
                    seq_reg                      <= seq_next;
                    res_item_reg.status          <= status_next;
                    res_item_reg.result_tag      <= rtag_next;
                    res_item_reg.result_priority <= rpri_next;
                    res_item_reg.entry_count     <= COUNT_W'(count_next);
                    res_valid_reg                <= 1'b1;
                    state_reg                    <= HANDOFF;
                end
                HANDOFF: begin
                    if (res_ready) begin
                        res_valid_reg <= 1'b0;
                        state_reg     <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
            if (take) begin
                found_reg    <= 1'b1;
                best_reg     <= rd_data;
                best_idx_reg <= rd_idx_reg;
            end
        end
    end

    `FTPQ_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `FTPQ_ASSERT_NOW(a_write_window, aclk, aresetn, mem_we, (state_reg == COMMIT) || (state_reg == CLEAR), "table write outside commit or clear")
    `FTPQ_ASSERT_NEXT(a_extract_count, aclk, aresetn, (state_reg == COMMIT) && (op_reg == OP_EXTRACT) && found_reg, count_reg == $past(count_reg) - 1'b1, "extract did not drop count")
    `FTPQ_ASSERT_NOW(a_busy_no_take, aclk, aresetn, state_reg != IDLE, !cmd_ready, "command taken while busy")

endmodule

// ===== tb/sv/tb_fifo_tiebreak_priority_queue.sv =====
`timescale 1ns / 100ps

module tb_fifo_tiebreak_priority_queue;
    import ftpq_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int RAND_ITEMS = 600;
    localparam int IDLE_LIMIT = 3000;
    localparam int DIR_ROWS   = 23;
    localparam logic [31:0] P_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] P_MIN = 32'h8000_0000;

    typedef enum int {PH_MIXED, PH_FILL, PH_DRAIN} phase_t;

    // One stimulus beat; a typed row carries its own expected result.
    typedef struct packed {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    fifo_tiebreak_priority_queue #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the entry table.
    bit                   q_valid [CAPACITY];
    logic [TAG_W-1:0]     q_tag   [CAPACITY];
    logic signed [31:0]   q_prio  [CAPACITY];
    logic [ORDER_W-1:0]   q_order [CAPACITY];
    logic [COUNT_W-1:0]   q_count = '0;
    logic [ORDER_W-1:0]   q_seq   = '0;

    stim_row_t stim_q [$];
    out_item_t pending_results [$];
    stim_row_t dir_tbl [DIR_ROWS];

    int errors    = 0;
    int n_checked = 0;
    int n_rand    = 0;
    int n_op [4]  = '{0, 0, 0, 0};
    int n_st [4]  = '{0, 0, 0, 0};

    function automatic void add_stim(stim_row_t row);
        stim_q.insert(stim_q.size(), row);
    endfunction

    function automatic void add_expect(out_item_t res);
        pending_results.insert(pending_results.size(), res);
    endfunction

    function automatic out_item_t queue_apply(in_item_t it);
        out_item_t r;
        int        slot;
        int        i;
        r    = '0;
        r.status = ST_OK;
        slot = -1;
        case (it.opcode)
            OP_INSERT: begin
                for (i = CAPACITY - 1; i >= 0; i--) begin
                    if (!q_valid[i]) slot = i;
                end
                if (slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    q_valid[slot] = 1'b1;
                    q_tag[slot]   = it.value_tag;
                    q_prio[slot]  = it.priority_req;
                    q_order[slot] = q_seq;
                    q_seq++;
                    q_count++;
                end
            end
            OP_EXTRACT, OP_PEEK: begin
                for (i = 0; i < CAPACITY; i++) begin
                    if (q_valid[i] && (slot < 0 || q_prio[i] > q_prio[slot] ||
                        (q_prio[i] == q_prio[slot] && q_order[i] < q_order[slot])))
                        slot = i;
                end
                if (slot < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.result_tag      = q_tag[slot];
                    r.result_priority = q_prio[slot];
                    if (it.opcode == OP_EXTRACT) begin
                        q_valid[slot] = 1'b0;
                        q_count--;
                    end
                end
            end
            default: begin
                for (i = 0; i < CAPACITY; i++) begin
                    if (q_valid[i] && q_tag[i] == it.value_tag &&
                        (slot < 0 || q_order[i] < q_order[slot]))
                        slot = i;
                end
                if (slot < 0) r.status = ST_NOT_FOUND;
                else q_prio[slot] = it.priority_req;
            end
        endcase
        r.entry_count = q_count;
        return r;
    endfunction

    function automatic stim_row_t drow(op_t op, logic [31:0] tag, logic [31:0] pri);
        stim_row_t r;
        r = '0;
        r.item.opcode       = op;
        r.item.value_tag    = tag;
        r.item.priority_req = pri;
        return r;
    endfunction

    function automatic stim_row_t trow(op_t op, logic [31:0] tag, logic [31:0] pri,
                                       status_t st, logic [31:0] rtag, logic [31:0] rpri,
                                       int cnt);
        stim_row_t r;
        r = drow(op, tag, pri);
        r.typed                = 1'b1;
        r.want.status          = st;
        r.want.result_tag      = rtag;
        r.want.result_priority = rpri;
        r.want.entry_count     = cnt[COUNT_W-1:0];
        return r;
    endfunction

    function automatic in_item_t random_item(phase_t ph);
        in_item_t it;
        int       r;
        int       p;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL:  it.opcode = (r < 90) ? OP_INSERT :
                                  op_t'($urandom_range(OP_EXTRACT, OP_MODIFY));
            PH_DRAIN: it.opcode = (r < 70) ? OP_EXTRACT :
                                  (r < 80) ? OP_PEEK : (r < 90) ? OP_MODIFY : OP_INSERT;
            default:  it.opcode = (r < 35) ? OP_INSERT : (r < 60) ? OP_EXTRACT :
                                  (r < 75) ? OP_PEEK : OP_MODIFY;
        endcase
        // Keep tags in a small pool so modify hits and duplicates are common.
        r = $urandom_range(0, 99);
        if (r < 40)      it.value_tag = $urandom_range(0, 7);
        else if (r < 75) it.value_tag = 32'hFFFF_FFF8 | $urandom_range(0, 7);
        else             it.value_tag = $urandom;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            p = $urandom_range(0, 6);
            it.priority_req = p - 3;
        end else if (r < 70) begin
            it.priority_req = $urandom;
        end else if (r < 85) begin
            case ($urandom_range(0, 3))
                0: it.priority_req = P_MAX;
                1: it.priority_req = P_MIN;
                2: it.priority_req = '0;
                default: it.priority_req = '1;
            endcase
        end else begin
            it.priority_req = P_MAX - $urandom_range(0, 2);
        end
        return it;
    endfunction

    // Sender: bursts of beats separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin : drive
        stim_row_t row;
        out_item_t pred;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) begin
                row  = stim_q.pop_front();
                pred = queue_apply(row.item);
                add_expect(row.typed ? row.want : pred);
                n_op[row.item.opcode]++;
                n_st[pred.status]++;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (stim_q.size() > 0) begin
                if (burst_left == 0) burst_left = $urandom_range(1, 16);
                s_valid <= 1'b1;
                s_item  <= stim_q[0].item;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: modes of free flow, random stalls and long holds.
    int rx_cycle   = 0;
    int rx_mode    = 0;
    int stall_left = 0;

    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(20, 150);
                end
            end
        endcase
    end

    always @(posedge aclk) begin : check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: status %0d tag %h",
                       m_item.status, m_item.result_tag);
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (m_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_item.status);
                    errors++;
                end
                if (m_item.result_tag !== want.result_tag) begin
                    $error("result_tag: expected %h, got %h",
                           want.result_tag, m_item.result_tag);
                    errors++;
                end
                if (m_item.result_priority !== want.result_priority) begin
                    $error("result_priority: expected %0d, got %0d",
                           want.result_priority, m_item.result_priority);
                    errors++;
                end
                if (m_item.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_item.entry_count);
                    errors++;
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("fifo_tiebreak_priority_queue test failed");
            $finish;
        end
    end

    initial begin : stimulus
        phase_t ph;
        int     len;
        int     k;
        int     i;
        for (i = 0; i < CAPACITY; i++) begin
            q_valid[i] = 1'b0;
            q_tag[i]   = '0;
            q_prio[i]  = '0;
            q_order[i] = '0;
        end
        dir_tbl = '{
            trow(OP_EXTRACT, 32'h0,         32'h0,  ST_EMPTY,     0, 0, 0),
            trow(OP_PEEK,    32'hFFFF_FFFF, '1,     ST_EMPTY,     0, 0, 0),
            trow(OP_MODIFY,  32'h1234_5678, 32'd5,  ST_NOT_FOUND, 0, 0, 0),
            trow(OP_INSERT,  32'hFFFF_FFFF, P_MAX,  ST_OK,        0, 0, 1),
            trow(OP_INSERT,  32'h0,         P_MIN,  ST_OK,        0, 0, 2),
            trow(OP_PEEK,    32'h0,         32'h0,  ST_OK, 32'hFFFF_FFFF, P_MAX, 2),
            // equal top priority: the older entry must still win
            trow(OP_INSERT,  32'hAAAA_AAAA, P_MAX,  ST_OK,        0, 0, 3),
            trow(OP_PEEK,    32'h0,         32'h0,  ST_OK, 32'hFFFF_FFFF, P_MAX, 3),
            trow(OP_EXTRACT, 32'h0,         32'h0,  ST_OK, 32'hFFFF_FFFF, P_MAX, 2),
            trow(OP_EXTRACT, 32'h0,         32'h0,  ST_OK, 32'hAAAA_AAAA, P_MAX, 1),
            // duplicate tags at the lowest priority
            trow(OP_INSERT,  32'h5555_5555, P_MIN,  ST_OK,        0, 0, 2),
            trow(OP_INSERT,  32'h5555_5555, P_MIN,  ST_OK,        0, 0, 3),
            trow(OP_MODIFY,  32'h5555_5555, 32'd100, ST_OK,       0, 0, 3),
            trow(OP_PEEK,    32'h0,         32'h0,  ST_OK, 32'h5555_5555, 32'd100, 3),
            trow(OP_MODIFY,  32'h0,         '1,     ST_OK,        0, 0, 3),
            trow(OP_EXTRACT, 32'h0,         32'h0,  ST_OK, 32'h5555_5555, 32'd100, 2),
            trow(OP_EXTRACT, 32'h0,         32'h0,  ST_OK, 32'h0, '1, 1),
            trow(OP_MODIFY,  32'h0,         32'h0,  ST_NOT_FOUND, 0, 0, 1),
            drow(OP_MODIFY,  32'h5555_5555, P_MAX),
            drow(OP_INSERT,  32'h8000_0001, 32'd1),
            drow(OP_EXTRACT, 32'hFFFF_FFFF, P_MAX),
            drow(OP_EXTRACT, 32'h0,         P_MIN),
            trow(OP_EXTRACT, 32'h0,         32'h0,  ST_EMPTY,     0, 0, 0)
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) add_stim(dir_tbl[i]);

        k = 0;
        while (n_rand < RAND_ITEMS) begin
            // open with a fill past capacity and a drain past empty
            if (k == 0)      ph = PH_FILL;
            else if (k == 1) ph = PH_DRAIN;
            else             ph = phase_t'($urandom_range(0, 2));
            len = (ph == PH_MIXED) ? $urandom_range(30, 80) : 90;
            for (i = 0; i < len; i++) add_stim(drow(OP_INSERT, 0, 0));
            for (i = stim_q.size() - len; i < stim_q.size(); i++)
                stim_q[i].item = random_item(ph);
            n_rand += len;
            while (stim_q.size() != 0) @(negedge aclk);
            // on the first pass and at random later, hold the sender until every pending result has drained
            if (k == 0 || $urandom_range(0, 2) == 0) begin
                while (pending_results.size() != 0) @(negedge aclk);
            end
            k++;
        end

        while (stim_q.size() != 0 || pending_results.size() != 0) @(negedge aclk);
        repeat (2 * (CAPACITY + 4)) @(negedge aclk);

        $display("ran %0d beats: %0d insert, %0d extract, %0d peek, %0d modify",
                 n_op[OP_INSERT] + n_op[OP_EXTRACT] + n_op[OP_PEEK] + n_op[OP_MODIFY],
                 n_op[OP_INSERT], n_op[OP_EXTRACT], n_op[OP_PEEK], n_op[OP_MODIFY]);
        $display("results checked %0d; full %0d, empty %0d, tag missing %0d",
                 n_checked, n_st[ST_FULL], n_st[ST_EMPTY], n_st[ST_NOT_FOUND]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("fifo_tiebreak_priority_queue test passed");
        end else begin
            $display("fifo_tiebreak_priority_queue test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ftpq_pkg.sv
rtl/core/ftpq_mem.sv
rtl/core/ftpq_ctrl.sv
rtl/core/fifo_tiebreak_priority_queue.sv
tb/sv/tb_fifo_tiebreak_priority_queue.sv
